// ===== hw/rtl/sha256_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared constants, command and status structs, and round functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LengthPos  = 56;
  localparam int unsigned Rounds     = 64;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [255:0] InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic       load_byte;   // write in_byte at fill position, advance count
    logic       load_pad;    // write pad byte at fill position
    logic       load_zero;   // write zero at fill position
    logic       load_len;    // write length byte (63 - len_idx) at fill position
    logic [2:0] len_idx;
    logic       fill_clr;    // restart fill position
    logic       comp_start;  // copy block to window, chain to working vars
    logic       round;       // run one round
    logic       comp_done;   // add working vars to chain
    logic       reinit;      // return to reset values
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] rnd;
  } stat_t;

  function automatic logic [31:0] k_const(input logic [5:0] idx);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[idx];
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== hw/rtl/sha256_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, length counter, message schedule, round unit and chain words.
// ----------------------------------------------------------------------------
module sha256_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha256_pkg::cmd_t   cmd_i,
  input  logic [7:0]         in_byte_i,
  output sha256_pkg::stat_t  stat_o,
  output logic [255:0]       chain_o
);

  logic [511:0] buf_q;
  logic [5:0]   fill_q, fill_d;
  logic [63:0]  total_q, total_d;
  logic [5:0]   rnd_q, rnd_d;
  logic [31:0]  win_q [16];
  logic [31:0]  v_q [8];
  logic [255:0] chain_q, chain_d;
  logic [63:0]  bits;
  logic [7:0]   wr_byte;
  logic         wr_en;
  logic [31:0]  w, s0, s1, t1, t2, w15, w2;

  assign bits = {total_q[60:0], 3'b000};

  always_comb begin
    wr_en   = cmd_i.load_byte | cmd_i.load_pad | cmd_i.load_zero | cmd_i.load_len;
    wr_byte = 8'h00;
    if (cmd_i.load_byte) begin
      wr_byte = in_byte_i;
    end else if (cmd_i.load_pad) begin
      wr_byte = sha256_pkg::PadByte;
    end else if (cmd_i.load_len) begin
      wr_byte = bits[{cmd_i.len_idx, 3'b000} +: 8];
    end
  end

  // Every block gets exactly 64 writes, so bytes shift in from the low end and
  // the first byte of the block ends up in the top bits.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buf_q <= {buf_q[503:0], wr_byte};
    end
  end

  always_comb begin
    fill_d  = fill_q;
    total_d = total_q;
    if (wr_en) begin
      fill_d = fill_q + 6'd1;
    end
    if (cmd_i.load_byte) begin
      total_d = total_q + 64'd1;
    end
    if (cmd_i.fill_clr) begin
      fill_d = '0;
    end
    if (cmd_i.reinit) begin
      fill_d  = '0;
      total_d = '0;
    end
  end

  // Rolling schedule: window slot 0 always holds the word for this round.
  assign w15 = win_q[1];
  assign w2  = win_q[14];
  assign s0  = sha256_pkg::ror(w15, 7) ^ sha256_pkg::ror(w15, 18) ^ (w15 >> 3);
  assign s1  = sha256_pkg::ror(w2, 17) ^ sha256_pkg::ror(w2, 19) ^ (w2 >> 10);
  assign w   = win_q[0];
  assign t1  = v_q[7] + (sha256_pkg::ror(v_q[4], 6) ^ sha256_pkg::ror(v_q[4], 11)
             ^ sha256_pkg::ror(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
             + sha256_pkg::k_const(rnd_q) + w;
  assign t2  = (sha256_pkg::ror(v_q[0], 2) ^ sha256_pkg::ror(v_q[0], 13)
             ^ sha256_pkg::ror(v_q[0], 22))
             + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_ff @(posedge clk_i) begin
    if (cmd_i.comp_start) begin
      for (int j = 0; j < 16; j++) begin
        win_q[j] <= buf_q[511-32*j -: 32];
      end
      for (int j = 0; j < 8; j++) begin
        v_q[j] <= chain_q[32*j +: 32];
      end
    end else if (cmd_i.round) begin
      for (int j = 0; j < 15; j++) begin
        win_q[j] <= win_q[j+1];
      end
      win_q[15] <= win_q[0] + s0 + win_q[9] + s1;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_comb begin
    rnd_d = rnd_q;
    if (cmd_i.comp_start) begin
      rnd_d = '0;
    end else if (cmd_i.round) begin
      rnd_d = rnd_q + 6'd1;
    end
  end

  always_comb begin
    chain_d = chain_q;
    if (cmd_i.comp_done) begin
      for (int j = 0; j < 8; j++) begin
        chain_d[32*j +: 32] = chain_q[32*j +: 32] + v_q[j];
      end
    end
    if (cmd_i.reinit) begin
      chain_d = sha256_pkg::InitHash;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      total_q <= '0;
      rnd_q   <= '0;
      chain_q <= sha256_pkg::InitHash;
    end else begin
      fill_q  <= fill_d;
      total_q <= total_d;
      rnd_q   <= rnd_d;
      chain_q <= chain_d;
    end
  end

  assign stat_o.fill = fill_q;
  assign stat_o.rnd  = rnd_q;
  assign chain_o     = chain_q;

endmodule

// ===== hw/rtl/sha256_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte loads, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               present_i,
  input  logic               end_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [2:0]         out_idx_o,
  input  sha256_pkg::stat_t  stat_i,
  output sha256_pkg::cmd_t   cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StStart = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StAdd   = 3'd3;
  localparam logic [2:0] StPad   = 3'd4;
  localparam logic [2:0] StZero  = 3'd5;
  localparam logic [2:0] StLen   = 3'd6;
  localparam logic [2:0] StOut   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       fin_q, fin_d;    // message is ending
  logic       last_q, last_d;  // block being compressed holds the length
  logic       pend_q, pend_d;  // end request still to be padded after compression
  logic [2:0] cnt_q, cnt_d;
  logic       acc;

  assign acc         = in_valid_i & in_ready_o;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_idx_o   = cnt_q;

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    last_d  = last_q;
    pend_d  = pend_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (acc) begin
          cmd_o.load_byte = present_i;
          if (present_i && stat_i.fill == 6'd63) begin
            state_d = StStart;
            pend_d  = end_i;
            last_d  = 1'b0;
          end else if (end_i) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        cmd_o.load_pad = 1'b1;
        pend_d         = 1'b0;
        if (stat_i.fill >= 6'(sha256_pkg::LengthPos)) begin
          // A pad byte in the last slot already completes the block.
          state_d = (stat_i.fill == 6'd63) ? StStart : StZero;
          last_d  = 1'b0;
          fin_d   = 1'b1;
        end else begin
          state_d = (stat_i.fill == 6'(sha256_pkg::LengthPos - 1)) ? StLen : StZero;
          last_d  = 1'b1;
          cnt_d   = 3'd7;
        end
      end
      StZero: begin
        if (last_q) begin
          cmd_o.load_zero = 1'b1;
          if (stat_i.fill == 6'(sha256_pkg::LengthPos - 1)) begin
            state_d = StLen;
            cnt_d   = 3'd7;
          end
        end else begin
          // Pad out a block that has no room for the length.
          cmd_o.load_zero = 1'b1;
          if (stat_i.fill == 6'd63) begin
            state_d = StStart;
          end
        end
      end
      StLen: begin
        cmd_o.load_len = 1'b1;
        cmd_o.len_idx  = cnt_q;
        cnt_d          = cnt_q - 3'd1;
        if (cnt_q == 3'd0) begin
          state_d = StStart;
        end
      end
      StStart: begin
        cmd_o.comp_start = 1'b1;
        state_d          = StRound;
      end
      StRound: begin
        cmd_o.round = 1'b1;
        if (stat_i.rnd == 6'(sha256_pkg::Rounds - 1)) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        cmd_o.comp_done = 1'b1;
        cnt_d           = 3'd0;
        if (last_q) begin
          state_d = StOut;
        end else if (fin_q) begin
          // Second padding block: zeros up to the length field.
          fin_d   = 1'b0;
          last_d  = 1'b1;
          state_d = StZero;
        end else if (pend_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'd7) begin
            cmd_o.reinit = 1'b1;
            last_d       = 1'b0;
            state_d      = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fin_q   <= 1'b0;
      last_q  <= 1'b0;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      last_q  <= last_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and returns the eight digest words per message.
// ----------------------------------------------------------------------------
// Usage: each input item on the s_axis channel carries one optional byte and
// an end flag. Bytes are accepted one per cycle into the 64-byte block buffer;
// when the buffer fills, the block is compressed with one round per cycle
// (load, 64 rounds, chain add), during which s_axis_tready is low. An end item
// pads the message: the pad byte, zeros and length fill the remaining buffer
// bytes, with a second block of zeros and length and a second compression
// when the length does not fit. The digest then appears on m_axis as eight
// items, word 0 first, tlast on word 7; a stalled receiver simply holds the
// current word. After word 7 is taken the block is back in its reset state.
// Throughput is limited by the single round unit: no byte is accepted while a
// block is compressed. Reset loads the initial hash values and clears counts.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // msg_byte
  input  logic        s_axis_tuser,   // byte_present
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32], zeros
  output logic        m_axis_tlast    // last_word
);

  sha256_pkg::cmd_t  cmd;
  sha256_pkg::stat_t stat;
  logic [255:0]      chain;
  logic [2:0]        idx;

  sha256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .present_i   (s_axis_tuser),
    .end_i       (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_idx_o   (idx),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sha256_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_byte_i (s_axis_tdata),
    .stat_o    (stat),
    .chain_o   (chain)
  );

  assign m_axis_tdata = {5'b0, idx, chain[32*idx +: 32]};
  assign m_axis_tlast = (idx == 3'd7);

  // The input is never taken while a digest is being delivered.
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready during output");

  // Word index advances by one after each delivered word.
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
    else $error("word index skipped");

  // Output begins at word 0.
  a_first_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> m_axis_tdata[34:32] == 3'd0) else $error("bad first word");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Drives byte items with random gaps and end flags. A built-in SHA-256 model
// predicts each digest word, and a scoreboard compares every digest word
// the block returns against that prediction.
// ----------------------------------------------------------------------------
module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_item_t;

  always #5 clk_i = ~clk_i;

  sha256_stream_hasher DUT (.*);

  class digest_scoreboard;
    logic [31:0] chain [8];
    logic [7:0]  block [64];
    int unsigned fill;
    logic [63:0] total;
    digest_item_t pending [$];
    int          errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = sha256_pkg::InitHash[32*i +: 32];
      fill = 0;
      total = '0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int j = 0; j < 16; j++)
        w[j] = {block[4*j], block[4*j+1], block[4*j+2], block[4*j+3]};
      for (int r = 16; r < 64; r++) begin
        s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
        s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
        w[r] = w[r-16] + s0 + w[r-7] + s1;
      end
      for (int j = 0; j < 8; j++) v[j] = chain[j];
      for (int r = 0; r < 64; r++) begin
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::k_const(r[5:0]) + w[r];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        for (int j = 7; j > 0; j--) v[j] = v[j-1];
        v[4] = v[4] + t1;
        v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) chain[j] += v[j];
    endfunction

    function void note_input(logic [7:0] b, logic present, logic eom);
      logic [63:0] bits;
      int unsigned pos;
      if (present) begin
        block[fill] = b;
        fill++;
        total++;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end
      if (!eom) return;
      bits = total << 3;
      pos = fill;
      block[pos++] = sha256_pkg::PadByte;
      if (pos > sha256_pkg::LengthPos) begin
        while (pos < 64) block[pos++] = 8'h00;
        compress();
        pos = 0;
      end
      while (pos < sha256_pkg::LengthPos) block[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) block[63-i] = bits[8*i +: 8];
      compress();
      for (int i = 0; i < 8; i++) pending.push_back({chain[i], i[2:0], i == 7});
      restart();
    endfunction

    function void check_result(digest_item_t got);
      digest_item_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected digest word %h idx %0d", $time, got.word, got.idx);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.word !== exp.word) begin
        $display("%0t: digest_word expected %h actual %h", $time, exp.word, got.word);
        errors++;
      end
      if (got.idx !== exp.idx) begin
        $display("%0t: word_index expected %0d actual %0d", $time, exp.idx, got.idx);
        errors++;
      end
      if (got.last !== exp.last) begin
        $display("%0t: last_word expected %0b actual %0b", $time, exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  digest_scoreboard sb = new();
  bit drain_stalls = 1'b1;

  // Sends one item; gap idles the bus first, zero gap keeps tvalid high.
  task automatic send_item(logic [7:0] b, logic present, logic eom, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= present;
    s_axis_tlast  <= eom;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(b, present, eom);
    @(negedge clk_i);
  endtask

  task automatic send_message(int len, bit gaps, bit noise);
    for (int i = 0; i < len; i++) begin
      if (noise && $urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0, gaps);
      send_item(8'($urandom), 1'b1, 1'b0, gaps);
    end
    if ($urandom_range(0, 1)) send_item(8'($urandom), 1'b1, 1'b1, gaps);
    else send_item(8'($urandom), 1'b0, 1'b1, gaps);
  endtask

  // Receiver: random stall per word, with stall-free stretches.
  initial begin
    int stall;
    forever begin
      stall = drain_stalls ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result({m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast});
      @(negedge clk_i);
    end
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed: empty message, empty items, byte extremes, padding borders.
    send_item(8'h00, 1'b0, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0, 1'b0);
    send_item(8'ha5, 1'b1, 1'b1, 1'b0);
    drain_stalls = 1'b0;
    send_message(55, 1'b0, 1'b0);
    send_message(56, 1'b0, 1'b0);
    send_message(63, 1'b1, 1'b0);
    send_message(64, 1'b1, 1'b1);
    drain_stalls = 1'b1;
    // A few short random messages.
    for (int m = 0; m < 2; m++)
      send_message($urandom_range(0, 15), 1'b1, 1'b1);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
